### sv/quadratic_root_solver_defines.svh
// Assertion macros shared by the checker of the quadratic root solver.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qrs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qrs assertion failed");

`endif

### sv/qrs_pkg.sv
// Package of the quadratic root solver: widths, kind codes and stage records.
// No dependencies.
package qrs_pkg;

   localparam int COEF_BITS  = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DISC_W     = 34;
   localparam int ROOT_OUT_W = 40;
   localparam int KIND_W     = 2;

   localparam int PROD_W  = 2 * COEF_BITS;
   localparam int DCALC_W = 2 * COEF_BITS + 2;
   localparam int MAG_W   = DCALC_W;
   localparam int RAD_W   = MAG_W + 2 * FRAC_BITS;
   localparam int PAIRS   = RAD_W / 2;
   localparam int ROOT_W  = PAIRS;
   localparam int REM_W   = ROOT_W + 2;
   localparam int NB_W    = COEF_BITS + FRAC_BITS + 1;
   localparam int NSUM_W  = ((NB_W > ROOT_W + 1) ? NB_W : ROOT_W + 1) + 1;
   localparam int NUM_W   = NSUM_W + 1;
   localparam int ABS_W   = COEF_BITS;
   localparam int DEN_W   = COEF_BITS + 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPEATED = 2'd0,
      KIND_DISTINCT = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_DEGEN    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [DCALC_W-1:0] disc;
      logic signed [NB_W-1:0]    nb;
      logic [ABS_W-1:0]          abs_a;
      logic                      a_neg;
   } side_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [DCALC_W-1:0] disc;
      logic                      neg0;
      logic                      neg1;
   } tail_type;

endpackage

### sv/qrs_if.sv
// Valid/ready channel interfaces for coefficient requests and root responses.
// Depends on qrs_pkg.
interface qrs_req_if;
   import qrs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [COEF_BITS-1:0] coef_a;
   logic signed [COEF_BITS-1:0] coef_b;
   logic signed [COEF_BITS-1:0] coef_c;
   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if;
   import qrs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [KIND_W-1:0]            root_kind;
   logic signed [DISC_W-1:0]     discriminant;
   logic signed [ROOT_OUT_W-1:0] first_real;
   logic signed [ROOT_OUT_W-1:0] first_imag;
   logic signed [ROOT_OUT_W-1:0] second_real;
   logic signed [ROOT_OUT_W-1:0] second_imag;
   modport source (output valid, root_kind, discriminant, first_real, first_imag,
                   second_real, second_imag, input ready);
   modport sink (input valid, root_kind, discriminant, first_real, first_imag,
                 second_real, second_imag, output ready);
endinterface

### sv/qrs_sqrt.sv
// Pipelined digit-by-digit integer square root, one bit pair per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [qrs_pkg::MAG_W-1:0]  mag,
   output logic [qrs_pkg::ROOT_W-1:0] root
);
   import qrs_pkg::*;

   logic [REM_W-1:0]  rem_ff  [PAIRS];
   logic [ROOT_W-1:0] root_ff [PAIRS];
   logic [MAG_W-1:0]  mag_ff  [PAIRS];

   for (genvar j = 0; j < PAIRS; j++) begin : g_stage
      localparam int PI = PAIRS - 1 - j;
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [MAG_W-1:0]  mag_p;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (j == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign mag_p  = mag;
      end else begin : g_next
         assign rem_p  = rem_ff[j-1];
         assign root_p = root_ff[j-1];
         assign mag_p  = mag_ff[j-1];
      end

      always_comb begin
         rad    = RAD_W'(mag_p) << (2 * FRAC_BITS);
         rem_sh = {rem_p[REM_W-3:0], rad[2*PI+1 -: 2]};
         trial  = {root_p, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_p[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            mag_ff[j]  <= mag_p;
         end
      end
   end

   assign root = root_ff[PAIRS-1];

endmodule

### sv/qrs_div.sv
// Pipelined restoring divider for unsigned values, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [qrs_pkg::NUM_W-1:0] num,
   input  logic [qrs_pkg::DEN_W-1:0] den,
   output logic [qrs_pkg::NUM_W-1:0] quo
);
   import qrs_pkg::*;

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar j = 0; j < NUM_W; j++) begin : g_stage
      localparam int BI = NUM_W - 1 - j;
      logic [DEN_W-1:0] rem_p;
      logic [NUM_W-1:0] num_p;
      logic [NUM_W-1:0] quo_p;
      logic [DEN_W-1:0] den_p;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = num;
         assign quo_p = '0;
         assign den_p = den;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign num_p = num_ff[j-1];
         assign quo_p = quo_ff[j-1];
         assign den_p = den_ff[j-1];
      end

      always_comb begin
         rem_sh = {rem_p, num_p[BI]};
         quo_in = quo_p;
         if (rem_sh >= {1'b0, den_p}) begin
            rem_in     = DEN_W'(rem_sh - {1'b0, den_p});
            quo_in[BI] = 1'b1;
         end else begin
            rem_in = DEN_W'(rem_sh);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            num_ff[j] <= num_p;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_p;
         end
      end
   end

   assign quo = quo_ff[NUM_W-1];

endmodule

### sv/quadratic_root_solver.sv
// Throughput: one equation per cycle; the square root and both dividers are fully
// pipelined, one bit pair or quotient bit per stage, and the whole pipe holds on a stall.
// Reset: synchronous, clears every valid bit; payload registers are not reset.
// Depends on qrs_pkg, qrs_if, qrs_sqrt and qrs_div.
module quadratic_root_solver (
   input  logic     clock,
   input  logic     reset,
   qrs_req_if.sink  req_chan,
   qrs_rsp_if.source rsp_chan
);
   import qrs_pkg::*;

   logic en;

   logic                        v1_ff;
   logic signed [COEF_BITS-1:0] a1_ff, b1_ff;
   logic signed [PROD_W-1:0]    bb1_ff, ac1_ff;

   logic                        v2_ff;
   side_type                    side2_ff, side2_in;
   logic [MAG_W-1:0]            mag2_ff, mag2_in;
   logic signed [DCALC_W-1:0]   d2;

   side_type                    sdl_ff [PAIRS];
   logic [PAIRS-1:0]            vdl_ff;
   logic [ROOT_W-1:0]           root;

   logic                        v3_ff;
   logic [NUM_W-1:0]            num0_ff, num1_ff, num0_in, num1_in;
   logic [DEN_W-1:0]            den3_ff, den3_in;
   tail_type                    tail3_ff, tail3_in;
   logic signed [NSUM_W-1:0]    nbx, sx, n0, n1;
   side_type                    sq_side;

   tail_type                    tdl_ff [NUM_W];
   logic [NUM_W-1:0]            vtl_ff;
   logic [NUM_W-1:0]            quo0, quo1;

   logic                         vo_ff;
   logic [KIND_W-1:0]            kind_ff;
   logic signed [DISC_W-1:0]     disc_ff;
   logic signed [ROOT_OUT_W-1:0] r1_ff, i1_ff, r2_ff, i2_ff;
   logic signed [ROOT_OUT_W-1:0] r1_in, i1_in, r2_in, i2_in, q0s, q1s;
   tail_type                     tail_o;

   assign en             = !vo_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         vdl_ff <= '0;
         v3_ff  <= 1'b0;
         vtl_ff <= '0;
         vo_ff  <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_chan.valid;
         v2_ff  <= v1_ff;
         vdl_ff <= {vdl_ff[PAIRS-2:0], v2_ff};
         v3_ff  <= vdl_ff[PAIRS-1];
         vtl_ff <= {vtl_ff[NUM_W-2:0], v3_ff};
         vo_ff  <= vtl_ff[NUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= req_chan.coef_a;
         b1_ff  <= req_chan.coef_b;
         bb1_ff <= req_chan.coef_b * req_chan.coef_b;
         ac1_ff <= req_chan.coef_a * req_chan.coef_c;
      end
   end

   always_comb begin
      d2             = DCALC_W'(bb1_ff) - (DCALC_W'(ac1_ff) <<< 2);
      mag2_in        = d2[DCALC_W-1] ? MAG_W'(-d2) : MAG_W'(d2);
      side2_in.disc  = d2;
      side2_in.nb    = -(NB_W'(b1_ff) <<< FRAC_BITS);
      side2_in.abs_a = a1_ff[COEF_BITS-1] ? ABS_W'(-a1_ff) : ABS_W'(a1_ff);
      side2_in.a_neg = a1_ff[COEF_BITS-1];
      if (a1_ff == '0) begin
         side2_in.kind = KIND_DEGEN;
      end else if (d2[DCALC_W-1]) begin
         side2_in.kind = KIND_COMPLEX;
      end else if (d2 == '0) begin
         side2_in.kind = KIND_REPEATED;
      end else begin
         side2_in.kind = KIND_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side2_in;
         mag2_ff  <= mag2_in;
         sdl_ff[0] <= side2_ff;
         for (int i = 1; i < PAIRS; i++) begin
            sdl_ff[i] <= sdl_ff[i-1];
         end
      end
   end

   qrs_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .mag   (mag2_ff),
      .root  (root)
   );

   always_comb begin
      sq_side = sdl_ff[PAIRS-1];
      nbx     = NSUM_W'(sq_side.nb);
      sx      = NSUM_W'(signed'({1'b0, root}));
      if (sq_side.kind == KIND_COMPLEX) begin
         n0 = nbx;
         n1 = sx;
      end else begin
         n0 = nbx + sx;
         n1 = nbx - sx;
      end
      num0_in = (n0[NSUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0)) + NUM_W'(sq_side.abs_a);
      num1_in = (n1[NSUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1)) + NUM_W'(sq_side.abs_a);
      den3_in = (sq_side.kind == KIND_DEGEN) ? DEN_W'(1) : {sq_side.abs_a, 1'b0};
      tail3_in.kind = sq_side.kind;
      tail3_in.disc = sq_side.disc;
      tail3_in.neg0 = n0[NSUM_W-1] ^ sq_side.a_neg;
      tail3_in.neg1 = n1[NSUM_W-1] ^ sq_side.a_neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num0_ff  <= num0_in;
         num1_ff  <= num1_in;
         den3_ff  <= den3_in;
         tail3_ff <= tail3_in;
         tdl_ff[0] <= tail3_ff;
         for (int i = 1; i < NUM_W; i++) begin
            tdl_ff[i] <= tdl_ff[i-1];
         end
      end
   end

   qrs_div u_div0 (
      .clock (clock),
      .en    (en),
      .num   (num0_ff),
      .den   (den3_ff),
      .quo   (quo0)
   );

   qrs_div u_div1 (
      .clock (clock),
      .en    (en),
      .num   (num1_ff),
      .den   (den3_ff),
      .quo   (quo1)
   );

   always_comb begin
      tail_o = tdl_ff[NUM_W-1];
      q0s    = tail_o.neg0 ? -ROOT_OUT_W'(quo0) : ROOT_OUT_W'(quo0);
      q1s    = tail_o.neg1 ? -ROOT_OUT_W'(quo1) : ROOT_OUT_W'(quo1);
      case (tail_o.kind)
         KIND_DEGEN: begin
            r1_in = '0;
            i1_in = '0;
            r2_in = '0;
            i2_in = '0;
         end
         KIND_COMPLEX: begin
            r1_in = q0s;
            r2_in = q0s;
            i1_in = q1s;
            i2_in = -q1s;
         end
         default: begin
            r1_in = q0s;
            r2_in = q1s;
            i1_in = '0;
            i2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= tail_o.kind;
         disc_ff <= DISC_W'(tail_o.disc);
         r1_ff   <= r1_in;
         i1_ff   <= i1_in;
         r2_ff   <= r2_in;
         i2_ff   <= i2_in;
      end
   end

   assign rsp_chan.valid        = vo_ff;
   assign rsp_chan.root_kind    = kind_ff;
   assign rsp_chan.discriminant = disc_ff;
   assign rsp_chan.first_real   = r1_ff;
   assign rsp_chan.first_imag   = i1_ff;
   assign rsp_chan.second_real  = r2_ff;
   assign rsp_chan.second_imag  = i2_ff;

endmodule

### sv/qrs_chk.sv
// Checker on the response port of the quadratic root solver, with its bind.
// Depends on qrs_pkg and quadratic_root_solver_defines.svh.
`include "quadratic_root_solver_defines.svh"

module qrs_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [qrs_pkg::KIND_W-1:0]            rsp_root_kind,
   input logic signed [qrs_pkg::DISC_W-1:0]     rsp_discriminant,
   input logic signed [qrs_pkg::ROOT_OUT_W-1:0] rsp_first_real,
   input logic signed [qrs_pkg::ROOT_OUT_W-1:0] rsp_first_imag,
   input logic signed [qrs_pkg::ROOT_OUT_W-1:0] rsp_second_real,
   input logic signed [qrs_pkg::ROOT_OUT_W-1:0] rsp_second_imag
);
   import qrs_pkg::*;

   `QRS_ASSERT_NXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_first_real))
   `QRS_ASSERT_IMP(a_degen, rsp_valid && rsp_root_kind == KIND_DEGEN, rsp_first_real == '0 && rsp_first_imag == '0 && rsp_second_real == '0 && rsp_second_imag == '0)
   `QRS_ASSERT_IMP(a_repeat, rsp_valid && rsp_root_kind == KIND_REPEATED, rsp_discriminant == '0 && rsp_first_real == rsp_second_real)
   `QRS_ASSERT_IMP(a_cplx, rsp_valid && rsp_root_kind == KIND_COMPLEX, rsp_discriminant[DISC_W-1] && rsp_first_real == rsp_second_real && rsp_second_imag == -rsp_first_imag)

endmodule

bind quadratic_root_solver qrs_chk u_qrs_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_root_kind    (rsp_chan.root_kind),
   .rsp_discriminant (rsp_chan.discriminant),
   .rsp_first_real   (rsp_chan.first_real),
   .rsp_first_imag   (rsp_chan.first_imag),
   .rsp_second_real  (rsp_chan.second_real),
   .rsp_second_imag  (rsp_chan.second_imag)
);

### tb/qrs_root_checker.sv
// Checker for the quadratic root solver: predicts the roots of each accepted
// equation and compares every response transfer with the oldest prediction.
// Depends on qrs_pkg and qrs_if.
module qrs_root_checker (
   input  logic        clock,
   input  logic        reset,
   qrs_req_if.sink     req_mon,
   qrs_rsp_if.sink     rsp_mon,
   output int          fail_count,
   output int          pending_count
);
   import qrs_pkg::*;

   typedef struct {
      kind_type                     kind;
      logic signed [DISC_W-1:0]     disc;
      logic signed [ROOT_OUT_W-1:0] r1;
      logic signed [ROOT_OUT_W-1:0] i1;
      logic signed [ROOT_OUT_W-1:0] r2;
      logic signed [ROOT_OUT_W-1:0] i2;
   } roots_type;

   roots_type expected_roots[$];

   function automatic longint unsigned root_floor(longint unsigned mag);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned pair;
      longint unsigned trial;
      rem = 0;
      root = 0;
      for (int i = 26 + FRAC_BITS - 1; i >= 0; i--) begin
         pair = 0;
         if (2 * i >= 2 * FRAC_BITS) begin
            pair = (mag >> (2 * i - 2 * FRAC_BITS)) & 64'd3;
         end
         rem = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint div_nearest(longint n, longint dv);
      longint unsigned un;
      longint unsigned ud;
      longint unsigned q;
      un = (n < 0) ? -n : n;
      ud = (dv < 0) ? -dv : dv;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (dv < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic roots_type solve_roots(logic signed [COEF_BITS-1:0] ca,
                                             logic signed [COEF_BITS-1:0] cb,
                                             logic signed [COEF_BITS-1:0] cc);
      roots_type res;
      longint a;
      longint b;
      longint c;
      longint d;
      longint nb;
      longint s;
      longint r1;
      longint i1;
      longint r2;
      longint i2;
      a = ca;
      b = cb;
      c = cc;
      d = b * b - 4 * a * c;
      r1 = 0;
      i1 = 0;
      r2 = 0;
      i2 = 0;
      if (a == 0) begin
         res.kind = KIND_DEGEN;
      end else begin
         nb = -b * (longint'(1) << FRAC_BITS);
         s = longint'(root_floor((d < 0) ? -d : d));
         if (d < 0) begin
            res.kind = KIND_COMPLEX;
            r1 = div_nearest(nb, 2 * a);
            r2 = r1;
            i1 = div_nearest(s, 2 * a);
            i2 = -i1;
         end else begin
            res.kind = (d > 0) ? KIND_DISTINCT : KIND_REPEATED;
            r1 = div_nearest(nb + s, 2 * a);
            r2 = div_nearest(nb - s, 2 * a);
         end
      end
      res.disc = d[DISC_W-1:0];
      res.r1 = r1[ROOT_OUT_W-1:0];
      res.i1 = i1[ROOT_OUT_W-1:0];
      res.r2 = r2[ROOT_OUT_W-1:0];
      res.i2 = i2[ROOT_OUT_W-1:0];
      return res;
   endfunction

   function automatic void compare_field(string name, logic [ROOT_OUT_W-1:0] exp_v,
                                         logic [ROOT_OUT_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      roots_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            expected_roots.push_back(solve_roots(req_mon.coef_a, req_mon.coef_b,
                                                 req_mon.coef_c));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: response transfer with no expectation, actual kind %0d",
                        $time, rsp_mon.root_kind);
               fail_count++;
            end else begin
               e = expected_roots.pop_front();
               compare_field("root_kind", e.kind, rsp_mon.root_kind);
               compare_field("discriminant", ROOT_OUT_W'(e.disc),
                             ROOT_OUT_W'(rsp_mon.discriminant));
               compare_field("first_real", e.r1, rsp_mon.first_real);
               compare_field("first_imag", e.i1, rsp_mon.first_imag);
               compare_field("second_real", e.r2, rsp_mon.second_real);
               compare_field("second_imag", e.i2, rsp_mon.second_imag);
            end
         end
      end
      pending_count <= expected_roots.size();
   end
endmodule

### tb/tb_top.sv
// Top of the quadratic root solver testbench: clock, reset, coefficient
// stimulus with idle and stall phases, and the verdict.
// Depends on qrs_pkg, qrs_if, quadratic_root_solver and qrs_root_checker.
module tb_top;
   import qrs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;

   qrs_req_if req_chan();
   qrs_rsp_if rsp_chan();

   quadratic_root_solver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   qrs_root_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (cycle_count > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [COEF_BITS-1:0] rand_coef();
      case ($urandom_range(5))
         0: return COEF_BITS'($urandom_range(7));
         1: return COEF_BITS'(-$urandom_range(8));
         2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         3: return COEF_BITS'($urandom_range(255) - 128);
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   task automatic send_equation(logic [COEF_BITS-1:0] a, logic [COEF_BITS-1:0] b,
                                logic [COEF_BITS-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.coef_a <= a;
      req_chan.coef_b <= b;
      req_chan.coef_c <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      logic [COEF_BITS-1:0] a;
      logic [COEF_BITS-1:0] m;
      logic [COEF_BITS-1:0] r;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         a = rand_coef();
         if ($urandom_range(3) == 0) begin
            // A perfect square b*b = 4ac gives a repeated root when a is not zero.
            m = COEF_BITS'(a % 16'd100) + COEF_BITS'(a == '0);
            r = COEF_BITS'($urandom_range(36)) - COEF_BITS'(18);
            send_equation(m, COEF_BITS'(2 * r * m), COEF_BITS'(r * r * m));
         end else begin
            send_equation(a, rand_coef(), rand_coef());
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.coef_a = '0;
      req_chan.coef_b = '0;
      req_chan.coef_c = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_equation(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_equation(16'sh8000, 16'sh8000, 16'sh8000);
      send_equation(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_equation(16'sh7fff, 16'sh8000, 16'sh8000);
      send_equation(16'sh8000, 16'sh0000, 16'sh7fff);
      send_equation(16'sh0001, 16'sh8000, 16'sh8000);
      send_equation(16'shffff, 16'shffff, 16'shffff);
      send_equation(16'sh0000, 16'sh0003, 16'sh0004);
      send_equation(16'sh0000, 16'sh0000, 16'sh0000);
      send_equation(16'sh0000, 16'sh8000, 16'sh7fff);
      send_equation(16'sh0001, 16'sh0002, 16'sh0001);
      send_equation(16'shffff, 16'sh0004, 16'shfffc);
      send_equation(16'sh0001, 16'sh0000, 16'shffff);
      send_equation(16'sh0002, 16'sh0001, 16'shfffd);
      send_equation(16'sh0001, 16'sh0000, 16'sh0001);
      send_equation(16'sh0003, 16'sh0001, 16'sh0005);
      send_equation(16'shfffe, 16'sh0001, 16'shfffb);
      send_equation(16'sh0001, 16'sh0001, 16'sh0000);
      send_equation(16'sh0004, 16'sh0002, 16'sh0000);
      send_equation(16'sh5555, 16'shaaaa, 16'sh5555);
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      run_phase(0, 0, 330);
      run_phase(66, 0, 330);
      run_phase(0, 66, 330);
      run_phase(20, 20, 330);
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

### files.f
+incdir+sv
sv/qrs_pkg.sv
sv/qrs_if.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
sv/qrs_chk.sv
tb/qrs_root_checker.sv
tb/tb_top.sv
